// ===== rtl/rbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbcd_pkg - shared types and constants
// Event codes, operation codes, register map and the event bundle that
// travels from the classifier to the result serializer.
// ----------------------------------------------------------------------------
package rbcd_pkg;

  localparam int OPERATION_W = 2;
  localparam int BUTTON_OP_W = 7;
  localparam int KIND_W      = 3;
  localparam int TICKS_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MAX_EVENTS  = 3;
  localparam int CNT_W       = 2;

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;

  localparam logic [TICKS_W-1:0] HOLD_RESET    = 16'd300;
  localparam logic [TICKS_W-1:0] RELEASE_RESET = 16'd2000;

  typedef enum logic [OPERATION_W-1:0] {
    OP_BUTTON     = 2'd0,
    OP_TICK       = 2'd1,
    OP_DISCONNECT = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    EV_ACK     = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_CLICK   = 3'd3,
    EV_RAW     = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [BUTTON_OP_W-1:0] op;
    logic                   fwd;
  } event_t;

  // ev[0] goes out first; cnt is the number of valid entries (0..3)
  typedef struct packed {
    event_t [MAX_EVENTS-1:0] ev;
    logic   [CNT_W-1:0]      cnt;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/rbcd_ifs.sv =====
// ----------------------------------------------------------------------------
// rbcd channel interfaces
// Valid/ready channels for button commands and for client events.
// ----------------------------------------------------------------------------
interface rbcd_in_if;
  import rbcd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OPERATION_W-1:0] operation;
  logic [BUTTON_OP_W-1:0] button_op;
  logic                   is_press;
  logic                   vendor_unique;

  modport source (output valid, operation, button_op, is_press, vendor_unique,
                  input ready);
  modport sink   (input valid, operation, button_op, is_press, vendor_unique,
                  output ready);
endinterface

interface rbcd_out_if;
  import rbcd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      event_kind;
  logic [BUTTON_OP_W-1:0] event_op;
  logic                   forward_press;
  logic                   last_of_run;

  modport source (output valid, event_kind, event_op, forward_press, last_of_run,
                  input ready);
  modport sink   (input valid, event_kind, event_op, forward_press, last_of_run,
                  output ready);
endinterface

// ===== rtl/rbcd_front.sv =====
// ----------------------------------------------------------------------------
// rbcd_front - command classifier
// Holds the pending press, the timer and the tick registers. Each accepted
// command updates the state and pushes a bundle of its events, if it has any.
// ----------------------------------------------------------------------------
module rbcd_front (
  input  logic                          clk,
  input  logic                          rst,
  rbcd_in_if.sink                       cmd,
  input  logic                          cfg_we,
  input  logic [rbcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbcd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  rbcd_pkg::q_stat_t             q_stat,
  output logic                          q_push,
  output rbcd_pkg::bundle_t             q_data
);
  import rbcd_pkg::*;

  logic [TICKS_W-1:0]     hold_ticks;
  logic [TICKS_W-1:0]     release_ticks;

  logic                   pending_valid,    pending_valid_next;
  logic [BUTTON_OP_W-1:0] pending_op,       pending_op_next;
  logic                   pending_click,    pending_click_next;
  logic                   pending_vendor,   pending_vendor_next;
  logic [TICKS_W-1:0]     timer_left,       timer_left_next;
  logic                   timer_is_release, timer_is_release_next;

  logic                   accept;
  logic [TICKS_W-1:0]     hold_load;
  logic [TICKS_W-1:0]     release_load;
  logic [TICKS_W-1:0]     timer_dec;
  logic                   same_op;
  bundle_t                b;

  // zero in a register counts as one tick
  assign hold_load    = (hold_ticks == '0) ? TICKS_W'(1) : hold_ticks;
  assign release_load = (release_ticks == '0) ? TICKS_W'(1) : release_ticks;
  assign timer_dec    = timer_left - TICKS_W'(1);
  assign same_op      = pending_valid && (pending_op == cmd.button_op);

  assign cmd.ready = !q_stat.full;
  assign accept    = cmd.valid && cmd.ready;
  assign q_push    = accept && (b.cnt != '0);
  assign q_data    = b;

  always_comb begin
    pending_valid_next    = pending_valid;
    pending_op_next       = pending_op;
    pending_click_next    = pending_click;
    pending_vendor_next   = pending_vendor;
    timer_left_next       = timer_left;
    timer_is_release_next = timer_is_release;
    b = '0;

    case (op_e'(cmd.operation))
      OP_BUTTON: begin
        b.ev[b.cnt] = '{kind: EV_ACK, op: cmd.button_op, fwd: 1'b0};
        b.cnt = b.cnt + CNT_W'(1);
        if (cmd.is_press) begin
          if (same_op) begin
            // repeat of the pending button
            if (pending_click) begin
              pending_click_next = 1'b0;
              b.ev[b.cnt] = '{kind: EV_PRESS, op: pending_op, fwd: 1'b0};
              b.cnt = b.cnt + CNT_W'(1);
            end
            timer_left_next       = release_load;
            timer_is_release_next = 1'b1;
          end else begin
            // close out the old press
            if (pending_valid) begin
              if (pending_click) begin
                b.ev[b.cnt] = '{kind: EV_CLICK, op: pending_op, fwd: 1'b0};
                b.cnt = b.cnt + CNT_W'(1);
              end else if (!pending_vendor) begin
                b.ev[b.cnt] = '{kind: EV_RELEASE, op: pending_op, fwd: 1'b0};
                b.cnt = b.cnt + CNT_W'(1);
              end
            end
            pending_valid_next  = 1'b1;
            pending_op_next     = cmd.button_op;
            pending_vendor_next = cmd.vendor_unique;
            if (!cmd.vendor_unique) begin
              pending_click_next    = 1'b1;
              timer_left_next       = hold_load;
              timer_is_release_next = 1'b0;
            end else begin
              pending_click_next    = 1'b0;
              b.ev[b.cnt] = '{kind: EV_RAW, op: cmd.button_op, fwd: 1'b1};
              b.cnt = b.cnt + CNT_W'(1);
              timer_left_next       = release_load;
              timer_is_release_next = 1'b1;
            end
          end
        end else if (same_op) begin
          if (pending_click) begin
            b.ev[b.cnt] = '{kind: EV_CLICK, op: pending_op, fwd: 1'b0};
          end else if (!cmd.vendor_unique) begin
            b.ev[b.cnt] = '{kind: EV_RELEASE, op: cmd.button_op, fwd: 1'b0};
          end else begin
            b.ev[b.cnt] = '{kind: EV_RAW, op: cmd.button_op, fwd: 1'b0};
          end
          b.cnt = b.cnt + CNT_W'(1);
          pending_valid_next    = 1'b0;
          pending_op_next       = '0;
          pending_click_next    = 1'b0;
          pending_vendor_next   = 1'b0;
          timer_left_next       = '0;
          timer_is_release_next = 1'b0;
        end
      end

      OP_TICK: begin
        if (timer_left != '0) begin
          timer_left_next = timer_dec;
          if (timer_dec == '0) begin
            if (!timer_is_release && pending_valid) begin
              // hold time over: report the press
              pending_click_next = 1'b0;
              b.ev[b.cnt] = '{kind: EV_PRESS, op: pending_op, fwd: 1'b0};
              b.cnt = b.cnt + CNT_W'(1);
              timer_left_next       = release_load;
              timer_is_release_next = 1'b1;
            end else begin
              if (pending_valid && !pending_click && !pending_vendor) begin
                b.ev[b.cnt] = '{kind: EV_RELEASE, op: pending_op, fwd: 1'b0};
                b.cnt = b.cnt + CNT_W'(1);
              end
              pending_valid_next    = 1'b0;
              pending_op_next       = '0;
              pending_click_next    = 1'b0;
              pending_vendor_next   = 1'b0;
              timer_is_release_next = 1'b0;
            end
          end
        end
      end

      OP_DISCONNECT: begin
        if (pending_valid && !pending_click && !pending_vendor) begin
          b.ev[b.cnt] = '{kind: EV_RELEASE, op: pending_op, fwd: 1'b0};
          b.cnt = b.cnt + CNT_W'(1);
        end
        pending_valid_next    = 1'b0;
        pending_op_next       = '0;
        pending_click_next    = 1'b0;
        pending_vendor_next   = 1'b0;
        timer_left_next       = '0;
        timer_is_release_next = 1'b0;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks       <= HOLD_RESET;
      release_ticks    <= RELEASE_RESET;
      pending_valid    <= 1'b0;
      pending_op       <= '0;
      pending_click    <= 1'b0;
      pending_vendor   <= 1'b0;
      timer_left       <= '0;
      timer_is_release <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HOLD:    hold_ticks    <= cfg_data[TICKS_W-1:0];
          CFG_RELEASE: release_ticks <= cfg_data[TICKS_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        pending_valid    <= pending_valid_next;
        pending_op       <= pending_op_next;
        pending_click    <= pending_click_next;
        pending_vendor   <= pending_vendor_next;
        timer_left       <= timer_left_next;
        timer_is_release <= timer_is_release_next;
      end
    end
  end

  // a running timer always belongs to a pending press
  a_timer_owned: assert property (@(posedge clk) disable iff (rst)
    (timer_left != '0) |-> pending_valid)
    else $error("timer running with no pending press");

  // a click candidate is a standard press still in its hold time
  a_click_shape: assert property (@(posedge clk) disable iff (rst)
    pending_click |-> (pending_valid && !pending_vendor && !timer_is_release))
    else $error("click candidate in inconsistent state");

endmodule

// ===== rtl/rbcd_queue.sv =====
// ----------------------------------------------------------------------------
// rbcd_queue - event bundle queue
// Short FIFO of event bundles between classifier and serializer.
// ----------------------------------------------------------------------------
module rbcd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rbcd_pkg::bundle_t push_data,
  input  logic              pop,
  output rbcd_pkg::bundle_t head,
  output rbcd_pkg::q_stat_t stat
);
  import rbcd_pkg::*;

  bundle_t             slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    bump = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/rbcd_back.sv =====
// ----------------------------------------------------------------------------
// rbcd_back - event serializer
// Walks the head bundle one event per cycle into the output register while evt takes them.
// ----------------------------------------------------------------------------
module rbcd_back (
  input  logic              clk,
  input  logic              rst,
  input  rbcd_pkg::q_stat_t q_stat,
  input  rbcd_pkg::bundle_t head,
  output logic              q_pop,
  rbcd_out_if.source        evt
);
  import rbcd_pkg::*;

  logic                   out_valid;
  kind_e                  out_kind;
  logic [BUTTON_OP_W-1:0] out_op;
  logic                   out_fwd;
  logic                   out_last;
  logic [CNT_W-1:0]       idx;

  logic                   load;
  logic                   last;
  event_t                 cur;

  assign load  = !q_stat.empty && (!out_valid || evt.ready);
  assign cur   = head.ev[idx];
  assign last  = (idx == head.cnt - CNT_W'(1));
  assign q_pop = load && last;

  assign evt.valid         = out_valid;
  assign evt.event_kind    = out_kind;
  assign evt.event_op      = out_op;
  assign evt.forward_press = out_fwd;
  assign evt.last_of_run   = out_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= cur.kind;
      out_op   <= cur.op;
      out_fwd  <= cur.fwd;
      out_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? '0 : idx + CNT_W'(1);
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // only non-empty bundles are queued, and the walk stays inside the bundle
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |-> (head.cnt != '0 && idx < head.cnt))
    else $error("event index outside head bundle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

// ===== rtl/remote_button_click_detector.sv =====
// ----------------------------------------------------------------------------
// remote_button_click_detector - remote button click detector
// Turns remote button commands, timer ticks and link drops into ack, press,
// release, click and raw vendor events for a client.
// ----------------------------------------------------------------------------
//
//  port       | dir | kind        | contents
//  -----------+-----+-------------+---------------------------------------------
//  cmd        | in  | valid/ready | operation, button_op, is_press, vendor_unique
//  evt        | out | valid/ready | event_kind, event_op, forward_press,
//             |     |             | last_of_run
//  cfg_*      | in  | write only  | cfg_index 0 hold_ticks, 1 release_ticks
//
//  A command is classified in the cycle it is accepted; its 0..3 events go
//  into a 2-entry bundle queue and reach evt through the output register.
//  The output register sends one event per cycle while evt is ready, so the
//  sustained rate is one command per cycle for commands giving one event;
//  commands giving several events are held to the pace of the result port.
//  Reset (rst, synchronous) clears the pending press and timer and loads
//  hold_ticks = 300, release_ticks = 2000. cmd.ready drops only when the
//  queue is full: after evt has been stalled, or when commands that give
//  several events each arrive faster than evt drains them; the two sides
//  stall apart.
//
module remote_button_click_detector (
  input  logic                            clk,
  input  logic                            rst,
  rbcd_in_if.sink                         cmd,
  rbcd_out_if.source                      evt,
  input  logic                            cfg_we,
  input  logic [rbcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbcd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rbcd_pkg::*;

  // classifier -> queue
  logic    q_push;
  bundle_t q_data;

  // queue -> serializer
  bundle_t q_head;
  q_stat_t q_stat;
  logic    q_pop;

  // front: takes commands, owns the pending press, timer and tick registers
  rbcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  // bundles that produced no event are never pushed
  rbcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // back: serializes the head bundle and flags the last event of each run
  rbcd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .head   (q_head),
    .q_pop  (q_pop),
    .evt    (evt)
  );

endmodule

// ===== sim/rbcd_event_checker.sv =====
// ----------------------------------------------------------------------------
// rbcd_event_checker - client event predictor and comparator
// Watches the command, event and register-write ports of the click detector,
// keeps its own model of the pending press and timer, and compares every
// event transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module rbcd_event_checker (
  input  logic                            clk,
  input  logic                            rst,
  rbcd_in_if                              cmd,
  rbcd_out_if                             evt,
  input  logic                            cfg_we,
  input  logic [rbcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbcd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              backlog,
  output int                              cmd_count,
  output int                              event_count,
  output int                              click_count,
  output int                              press_count,
  output int                              release_count,
  output int                              raw_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import rbcd_pkg::*;

  typedef struct packed {
    kind_e                  kind;
    logic [BUTTON_OP_W-1:0] op;
    logic                   fwd;
    logic                   last;
  } client_event_t;

  client_event_t expected_q[$];
  client_event_t batch[MAX_EVENTS];
  int            batch_len;

  logic [TICKS_W-1:0]     hold_cfg;
  logic [TICKS_W-1:0]     release_cfg;
  logic                   held_valid;
  logic [BUTTON_OP_W-1:0] held_op;
  logic                   held_click;
  logic                   held_vendor;
  logic [TICKS_W-1:0]     timer_left;
  logic                   timer_release;

  initial begin
    errors        = 0;
    backlog       = 0;
    cmd_count     = 0;
    event_count   = 0;
    click_count   = 0;
    press_count   = 0;
    release_count = 0;
    raw_count     = 0;
  end

  // a zero register means one tick
  function automatic logic [TICKS_W-1:0] at_least_one(input logic [TICKS_W-1:0] v);
    return (v == '0) ? TICKS_W'(1) : v;
  endfunction

  task automatic queue_event(input kind_e k, input logic [BUTTON_OP_W-1:0] op,
                             input logic fwd);
    if (batch_len < MAX_EVENTS) begin
      batch[batch_len] = '{k, op, fwd, 1'b0};
      batch_len++;
    end
  endtask

  task automatic arm_release_timer();
    timer_left    = at_least_one(release_cfg);
    timer_release = 1'b1;
  endtask

  task automatic drop_press();
    held_valid    = 1'b0;
    held_op       = '0;
    held_click    = 1'b0;
    held_vendor   = 1'b0;
    timer_left    = '0;
    timer_release = 1'b0;
  endtask

  // release only if the client has seen a standard press
  task automatic end_press();
    if (held_valid && !held_click && !held_vendor) queue_event(EV_RELEASE, held_op, 1'b0);
    drop_press();
  endtask

  task automatic start_press(input logic [BUTTON_OP_W-1:0] op, input logic vendor);
    held_valid  = 1'b1;
    held_op     = op;
    held_vendor = vendor;
    if (!vendor) begin
      held_click    = 1'b1;
      timer_left    = at_least_one(hold_cfg);
      timer_release = 1'b0;
    end else begin
      held_click = 1'b0;
      queue_event(EV_RAW, op, 1'b1);
      arm_release_timer();
    end
  endtask

  task automatic button_command(input logic [BUTTON_OP_W-1:0] op, input logic press,
                                input logic vendor);
    queue_event(EV_ACK, op, 1'b0);
    if (press) begin
      if (held_valid && held_op == op) begin
        if (held_click) begin
          held_click = 1'b0;
          queue_event(EV_PRESS, held_op, 1'b0);
        end
        arm_release_timer();
      end else begin
        if (held_valid) begin
          if (held_click) begin
            queue_event(EV_CLICK, held_op, 1'b0);
            drop_press();
          end else begin
            end_press();
          end
        end
        start_press(op, vendor);
      end
    end else if (held_valid && held_op == op) begin
      if (held_click) queue_event(EV_CLICK, held_op, 1'b0);
      else if (!vendor) queue_event(EV_RELEASE, op, 1'b0);
      else queue_event(EV_RAW, op, 1'b0);
      drop_press();
    end
  endtask

  task automatic tick_timer();
    if (timer_left == '0) return;
    timer_left--;
    if (timer_left != '0) return;
    if (!timer_release && held_valid) begin
      held_click = 1'b0;
      queue_event(EV_PRESS, held_op, 1'b0);
      arm_release_timer();
    end else begin
      end_press();
    end
  endtask

  task automatic predict_events(input logic [OPERATION_W-1:0] oper,
                                input logic [BUTTON_OP_W-1:0] op,
                                input logic press, input logic vendor);
    batch_len = 0;
    case (oper)
      OP_BUTTON:     button_command(op, press, vendor);
      OP_TICK:       tick_timer();
      OP_DISCONNECT: end_press();
      default: ;
    endcase
    if (batch_len > 0) batch[batch_len-1].last = 1'b1;
    for (int i = 0; i < batch_len; i++) expected_q.push_back(batch[i]);
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    client_event_t want;
    client_event_t got;
    if (rst) begin
      hold_cfg    = HOLD_RESET;
      release_cfg = RELEASE_RESET;
      drop_press();
      expected_q.delete();
    end else begin
      // events leaving now belong to commands taken at earlier edges
      if (evt.valid && evt.ready) begin
        got = '{kind_e'(evt.event_kind), evt.event_op, evt.forward_press, evt.last_of_run};
        event_count++;
        case (got.kind)
          EV_CLICK:   click_count++;
          EV_PRESS:   press_count++;
          EV_RELEASE: release_count++;
          EV_RAW:     raw_count++;
          default: ;
        endcase
        if (expected_q.size() == 0) begin
          $display("%0t ns: event kind %0d op %0d arrived, expected none",
                   $time, got.kind, got.op);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("event_kind", 8'(want.kind), 8'(got.kind));
          check_field("event_op", 8'(want.op), 8'(got.op));
          check_field("forward_press", 8'(want.fwd), 8'(got.fwd));
          check_field("last_of_run", 8'(want.last), 8'(got.last));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_HOLD) hold_cfg = cfg_data;
        else if (cfg_index == CFG_RELEASE) release_cfg = cfg_data;
      end
      if (cmd.valid && cmd.ready) begin
        cmd_count++;
        predict_events(cmd.operation, cmd.button_op, cmd.is_press, cmd.vendor_unique);
      end
    end
    backlog = expected_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - remote button click detector
// Drives button commands, ticks and link drops into the click detector under
// a series of hold/release timings, with random idling on both channels and
// one long client stall; the event checker predicts and compares every event.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rbcd_pkg::*;

  // operation code the block must drop
  localparam logic [OPERATION_W-1:0] OP_UNUSED = 2'd3;
  // register indexes past the map; writes there are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int STALL_LIMIT     = 2000; // cycles with no transaction at all
  localparam int HOLD_OFF_CYCLES = 80;   // long client stall
  localparam int SETTLE_CYCLES   = 6;    // pause before a register write
  localparam int TAIL_CYCLES     = 16;   // quiet time at the very end
  localparam int PHASE_ITEMS     = 75;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rbcd_in_if  cmd_if ();
  rbcd_out_if evt_if ();

  int errors;
  int backlog;
  int cmd_count;
  int event_count;
  int click_count;
  int press_count;
  int release_count;
  int raw_count;

  bit idle_on  = 1'b1; // random gaps on both sides
  int hold_ask = 0;    // bumped to request one long client stall
  int settings_used = 0;
  int quiet_cycles  = 0;

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  remote_button_click_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_if),
    .evt       (evt_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rbcd_event_checker i_event_check (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_if),
    .evt           (evt_if),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .backlog       (backlog),
    .cmd_count     (cmd_count),
    .event_count   (event_count),
    .click_count   (click_count),
    .press_count   (press_count),
    .release_count (release_count),
    .raw_count     (raw_count)
  );

  // --------------------------------------------------------------------------
  // Client side: ready comes in random runs; a hold-off request takes the
  // channel down for a long stretch so the block backs up into cmd.ready.
  // Each pass makes one assignment and then waits before the next pass.
  // --------------------------------------------------------------------------
  initial begin
    int hold_seen;
    hold_seen = 0;
    evt_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        evt_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        evt_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        evt_if.ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transaction on either channel resets the count.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (evt_if.valid && evt_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("[remote_button_click_detector] ERROR");
      $finish;
    end
  end

  // One command transaction. Called at a rising edge; returns at the edge
  // where the block took it. ready is sampled at the falling edge, where it
  // is settled, so acceptance never hinges on event order at the clock edge.
  task automatic send_command(input logic [OPERATION_W-1:0] oper,
                              input logic [BUTTON_OP_W-1:0] btn,
                              input logic prs, input logic vnd);
    logic taken;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.operation     <= oper;
    cmd_if.button_op     <= btn;
    cmd_if.is_press      <= prs;
    cmd_if.vendor_unique <= vnd;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cmd_if.ready;
      @(posedge clk);
    end
  endtask

  // Stop offering, wait until every predicted event has come out, then let
  // commands that produce nothing finish inside the block.
  task automatic drain(input int settle);
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // New timing while the channels are quiet. A press may still be pending;
  // its running timer keeps the old length, which the checker models too.
  task automatic set_timing(input logic [TICKS_W-1:0] hold, input logic [TICKS_W-1:0] rel);
    drain(SETTLE_CYCLES);
    write_register(CFG_HOLD, hold);
    write_register(CFG_RELEASE, rel);
    write_register(CFG_SPARE_A, CFG_DATA_W'($urandom_range(0, 65535)));
    write_register(CFG_SPARE_B, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly press/release pairs on a few buttons interleaved with ticks, so
  // clicks, timed presses and synthesized releases all come up; the rest is
  // stray buttons, link drops and the unused code.
  task automatic random_traffic(input int count);
    logic [BUTTON_OP_W-1:0] keys[3];
    logic [BUTTON_OP_W-1:0] btn;
    int roll;
    int done;
    for (int k = 0; k < 3; k++) keys[k] = BUTTON_OP_W'($urandom_range(0, 127));
    done = 0;
    while (done < count) begin
      roll = $urandom_range(0, 99);
      btn  = keys[$urandom_range(0, 2)];
      if (roll < 2) begin
        // dropped by the block, not counted
        send_command(OP_UNUSED, BUTTON_OP_W'($urandom_range(0, 127)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        if (roll < 42)
          send_command(OP_TICK, btn, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else if (roll < 70)
          send_command(OP_BUTTON, btn, 1'b1, $urandom_range(0, 4) == 0);
        else if (roll < 92)
          send_command(OP_BUTTON, btn, 1'b0, $urandom_range(0, 4) == 0);
        else if (roll < 96)
          send_command(OP_DISCONNECT, btn, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        else
          send_command(OP_BUTTON, BUTTON_OP_W'($urandom_range(0, 127)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        done++;
      end
    end
  endtask

  initial begin
    cmd_if.valid         = 1'b0;
    cmd_if.operation     = '0;
    cmd_if.button_op     = '0;
    cmd_if.is_press      = 1'b0;
    cmd_if.vendor_unique = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed, reset timing (hold 300, release 2000) ----
    send_command(OP_TICK, 7'd0, 1'b0, 1'b0);           // timer idle: nothing
    send_command(OP_DISCONNECT, 7'd0, 1'b0, 1'b0);     // nothing pending: nothing
    send_command(OP_UNUSED, 7'd127, 1'b1, 1'b1);       // unused code: ignored
    send_command(OP_BUTTON, 7'd0, 1'b0, 1'b0);         // release, none pending: ack
    send_command(OP_BUTTON, 7'd127, 1'b1, 1'b0);       // click candidate
    send_command(OP_BUTTON, 7'd127, 1'b0, 1'b0);       // quick release: click
    send_command(OP_BUTTON, 7'd5, 1'b1, 1'b0);
    send_command(OP_BUTTON, 7'd5, 1'b1, 1'b1);         // repeat press: press event now
    send_command(OP_BUTTON, 7'd5, 1'b0, 1'b0);         // standard release
    send_command(OP_BUTTON, 7'd9, 1'b1, 1'b0);
    send_command(OP_BUTTON, 7'd10, 1'b1, 1'b1);        // other press: click 9, raw 10
    send_command(OP_BUTTON, 7'd11, 1'b0, 1'b0);        // release of other button: ack
    send_command(OP_BUTTON, 7'd10, 1'b0, 1'b1);        // vendor release: raw
    send_command(OP_BUTTON, 7'd20, 1'b1, 1'b0);
    send_command(OP_DISCONNECT, 7'd20, 1'b0, 1'b0);    // drop click candidate silently
    send_command(OP_BUTTON, 7'd21, 1'b1, 1'b0);
    send_command(OP_BUTTON, 7'd21, 1'b1, 1'b0);
    send_command(OP_DISCONNECT, 7'd0, 1'b0, 1'b0);     // synthesized release
    send_command(OP_BUTTON, 7'd40, 1'b1, 1'b0);
    send_command(OP_BUTTON, 7'd40, 1'b1, 1'b0);
    send_command(OP_BUTTON, 7'd41, 1'b1, 1'b1);        // release 40, raw press 41

    // ---- directed, zero registers count as one tick ----
    set_timing(16'd0, 16'd0);
    send_command(OP_BUTTON, 7'd50, 1'b1, 1'b0);        // ends vendor 41, no release
    send_command(OP_TICK, 7'd0, 1'b0, 1'b0);           // hold expiry: press
    send_command(OP_TICK, 7'd0, 1'b0, 1'b0);           // release timeout
    send_command(OP_BUTTON, 7'd60, 1'b1, 1'b0);
    send_command(OP_TICK, 7'd0, 1'b0, 1'b0);
    send_command(OP_BUTTON, 7'd60, 1'b0, 1'b1);        // vendor-flagged release: raw
    send_command(OP_BUTTON, 7'd51, 1'b1, 1'b1);
    send_command(OP_TICK, 7'd0, 1'b0, 1'b0);           // vendor timeout: no release

    // ---- random phases under several timings ----
    set_timing(16'd1, 16'd1);
    random_traffic(PHASE_ITEMS);

    // long client stall while commands keep coming: queue fills, input stalls
    set_timing(16'd2, 16'd4);
    hold_ask++;
    random_traffic(PHASE_ITEMS);

    set_timing(16'd65535, 16'd65535);
    random_traffic(PHASE_ITEMS);

    set_timing(TICKS_W'($urandom_range(1, 8)), TICKS_W'($urandom_range(1, 16)));
    random_traffic(PHASE_ITEMS);

    set_timing(16'd3, 16'd65535);
    random_traffic(PHASE_ITEMS);

    // last stretch runs back to back on both sides
    set_timing(TICKS_W'($urandom_range(2, 6)), TICKS_W'($urandom_range(2, 10)));
    idle_on = 1'b0;
    random_traffic(PHASE_ITEMS);

    drain(TAIL_CYCLES);

    $display("Covered %0d commands under %0d timing settings, %0d events checked.",
             cmd_count, settings_used + 1, event_count);
    $display("Clicks %0d, presses %0d, releases %0d, raw vendor forwards %0d.",
             click_count, press_count, release_count, raw_count);
    if (errors == 0 && backlog == 0)
      $display("[remote_button_click_detector] OK");
    else
      $display("[remote_button_click_detector] ERROR");
    $finish;
  end

endmodule
